// ===== rtl/u8cf_pkg.sv =====
// Shared types, constants and lead-byte decode for the control-free UTF-8 checker.
`default_nettype none
package u8cf_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned OwedWidth = 3;

   localparam logic [ByteWidth-1:0] ContMask  = 8'hC0;
   localparam logic [ByteWidth-1:0] ContMark  = 8'h80;
   localparam logic [ByteWidth-1:0] PrintMin  = 8'd32;
   localparam logic [ByteWidth-1:0] LeadMin   = 8'hC0;
   localparam logic [ByteWidth-1:0] LeadMax   = 8'hFD;
   localparam logic [OwedWidth-1:0] MaxOwed   = 3'd5;

   typedef struct packed {
      logic [OwedWidth-1:0] owed;
      logic                 failed;
   } scan_state_type;

   typedef struct packed {
      scan_state_type next;
      logic           verdict;
   } step_result_type;

   function automatic logic [OwedWidth-1:0] owed_for_lead(input logic [ByteWidth-1:0] b);
      logic [OwedWidth-1:0] n;
      begin
         if (b < 8'hE0) begin
            n = 3'd1;
         end else if (b < 8'hF0) begin
            n = 3'd2;
         end else if (b < 8'hF8) begin
            n = 3'd3;
         end else if (b < 8'hFC) begin
            n = 3'd4;
         end else begin
            n = MaxOwed;
         end
         return n;
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/u8cf_step.sv =====
// Per-byte scan step: next sequence state and end-of-string verdict.
`default_nettype none
module u8cf_step (
   input  wire logic [u8cf_pkg::ByteWidth-1:0] data_byte,
   input  wire logic                           is_last,
   input  wire u8cf_pkg::scan_state_type       cur,
   output u8cf_pkg::step_result_type           res
);

   u8cf_pkg::scan_state_type upd;

   always_comb begin
      upd = cur;
      if (cur.owed != '0) begin
         if ((data_byte & u8cf_pkg::ContMask) != u8cf_pkg::ContMark) begin
            upd.failed = 1'b1;
         end
         upd.owed = cur.owed - 3'd1;
      end else if (data_byte < u8cf_pkg::ContMark) begin
         if (data_byte < u8cf_pkg::PrintMin) begin
            upd.failed = 1'b1;
         end
      end else if (data_byte inside {[u8cf_pkg::LeadMin:u8cf_pkg::LeadMax]}) begin
         upd.owed = u8cf_pkg::owed_for_lead(data_byte);
      end else begin
         upd.failed = 1'b1;
      end

      res.verdict = !upd.failed && (upd.owed == '0);
      if (is_last) begin
         res.next = '0;
      end else begin
         res.next = upd;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/utf8_control_free_validator.sv =====
// Top level of the control-free UTF-8 string checker.
//
//   channel  direction  ports                               moves
//   req      in         req_valid req_stall req_data_byte   one byte of a string
//                       req_is_last
//   rsp      out        rsp_valid rsp_stall rsp_valid_res   one verdict per string
//
// One byte per cycle while req_stall is low.
// Bytes pass an input register, then the scan step updates the sequence state
// and loads the verdict register.
// Synchronous active-high reset empties both registers and clears the state.
// A stalled verdict holds the last-byte request in the input register; other
// bytes keep flowing.
`default_nettype none
module utf8_control_free_validator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [u8cf_pkg::ByteWidth-1:0] req_data_byte,
   input  wire logic                           req_is_last,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_valid_res
);

   logic                           s1_valid_ff;
   logic [u8cf_pkg::ByteWidth-1:0] s1_byte_ff;
   logic                           s1_last_ff;
   u8cf_pkg::scan_state_type       state_ff;
   u8cf_pkg::scan_state_type       state_in;
   logic                           rsp_valid_ff;
   logic                           rsp_res_ff;
   u8cf_pkg::step_result_type      step;
   logic                           out_free;
   logic                           s1_go;
   logic                           req_take;

   u8cf_step u_step (
      .data_byte (s1_byte_ff),
      .is_last   (s1_last_ff),
      .cur       (state_ff),
      .res       (step)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;
   assign state_in  = s1_go ? step.next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // advance input register
         if (req_take) begin
            s1_valid_ff <= 1'b1;
            s1_byte_ff  <= req_data_byte;
            s1_last_ff  <= req_is_last;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         state_ff <= state_in;
         // load or drop verdict
         if (s1_go && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
            rsp_res_ff   <= step.verdict;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

   a_owed_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.owed <= u8cf_pkg::MaxOwed)
      else $error("owed count out of range");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff |=> state_ff == '0)
      else $error("state not cleared after string end");

   a_failed_verdict: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_last_ff && state_ff.failed |=> rsp_valid_ff && !rsp_res_ff)
      else $error("failed string reported valid");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("stall with empty input register");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_go |=> $stable(state_ff))
      else $error("state moved without a byte");

endmodule
`default_nettype wire
